FILE: rtl/rts_pkg.sv
// shared types, constants, sine table and helpers for the rhythmic turn state machine
package rts_pkg;

   localparam int PHASE_BITS      = 16;
   localparam int SINE_TABLE_BITS = 8;
   localparam int TIME_BITS       = 16;

   localparam int SINE_DEPTH = 1 << SINE_TABLE_BITS;
   localparam int CAP_W      = (TIME_BITS > 16) ? TIME_BITS : 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PHASE_STEP        = 3'd0,
      CSR_SPEAK_THETA_THR   = 3'd1,
      CSR_LISTEN_THETA_THR  = 3'd2,
      CSR_ENERGY_THR        = 3'd3,
      CSR_DEPLETION_THR     = 3'd4,
      CSR_SPEAK_GAMMA_THR   = 3'd5,
      CSR_MIN_DWELL_MS      = 3'd6,
      CSR_COOLDOWN_MS       = 3'd7
   } csr_index_type;

   localparam logic [15:0]        RST_PHASE_STEP       = 16'd393;
   localparam logic signed [15:0] RST_SPEAK_THETA_THR  = 16'sd21299;
   localparam logic signed [15:0] RST_LISTEN_THETA_THR = -16'sd9830;
   localparam logic [15:0]        RST_ENERGY_THR       = 16'd128;
   localparam logic [15:0]        RST_DEPLETION_THR    = 16'd51;
   localparam logic [15:0]        RST_SPEAK_GAMMA_THR  = 16'd102;
   localparam logic [15:0]        RST_MIN_DWELL_MS     = 16'd800;
   localparam logic [15:0]        RST_COOLDOWN_MS      = 16'd500;

   // 0.15 in q8.8 and q1.15
   localparam logic [15:0]        GAMMA_FLOOR   = 16'd38;
   localparam logic signed [15:0] ZERO_BAND_POS = 16'sd4915;
   localparam logic signed [15:0] ZERO_BAND_NEG = -16'sd4915;

   // floor(x / 10) = (x * ceil(2^24 / 10)) >> 24, exact for x below 2^22
   localparam int          DIV10_SHIFT = 24;
   localparam logic [20:0] DIV10_MULT  = 21'd1677722;

   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   typedef enum logic [2:0] {
      MODE_LISTEN = 3'b001,
      MODE_SPEAK  = 3'b010,
      MODE_TRANS  = 3'b100
   } turn_mode_type;

   localparam logic [1:0] CODE_LISTEN = 2'd0;
   localparam logic [1:0] CODE_SPEAK  = 2'd1;
   localparam logic [1:0] CODE_TRANS  = 2'd2;

   typedef struct packed {
      logic [15:0]        phase_step;
      logic signed [15:0] speak_theta_thr;
      logic signed [15:0] listen_theta_thr;
      logic [15:0]        energy_thr;
      logic [15:0]        depletion_thr;
      logic [15:0]        speak_gamma_thr;
      logic [15:0]        min_dwell_ms;
      logic [15:0]        cooldown_ms;
   } cfg_type;

   typedef struct packed {
      turn_mode_type         mode;
      logic                  heading_to_speak;
      logic [PHASE_BITS-1:0] phase;
      logic [15:0]           gamma;
      logic [TIME_BITS-1:0]  dwell;
      logic [TIME_BITS-1:0]  cooldown;
   } state_type;

   typedef struct packed {
      logic [9:0]  elapsed_ms;
      logic [15:0] energy_level;
      logic [15:0] gamma_sample;
   } item_type;

   typedef struct packed {
      logic [1:0]         turn_state;
      logic signed [15:0] theta_value;
      logic               state_changed;
   } result_type;

   typedef logic signed [15:0] sine_table_type [SINE_DEPTH];

   // quarter-wave odd polynomial in q30, rounded to q1.15
   function automatic logic signed [15:0] sine_q15(int unsigned idx);
      int unsigned qbits;
      int unsigned q;
      int unsigned quad;
      int unsigned r;
      int unsigned x;
      longint      t;
      longint      t2;
      longint      p;
      longint      s;
      qbits = SINE_TABLE_BITS - 2;
      q     = 1 << qbits;
      quad  = (idx >> qbits) & 3;
      r     = idx & (q - 1);
      x     = ((quad & 1) != 0) ? q - r : r;
      t     = longint'(x) << (30 - qbits);
      t2    = (t * t) >>> 30;
      p     = 172272;
      p     = 5026994 - ((p * t2) >>> 30);
      p     = 85569306 - ((p * t2) >>> 30);
      p     = 693598669 - ((p * t2) >>> 30);
      p     = 1686629713 - ((p * t2) >>> 30);
      s     = (t * p) >>> 30;
      s     = (s + 16384) >>> 15;
      if (s > 32767) begin
         s = 32767;
      end
      if ((quad & 2) != 0) begin
         s = -s;
      end
      return 16'(s);
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      for (int i = 0; i < SINE_DEPTH; i++) begin
         tbl[i] = sine_q15(i);
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

   // limit a 16-bit millisecond setting to the timer range
   function automatic logic [TIME_BITS-1:0] cap_time(logic [15:0] ms);
      logic [CAP_W-1:0] ms_ext;
      logic [CAP_W-1:0] max_ext;
      ms_ext  = CAP_W'(ms);
      max_ext = CAP_W'(TIME_MAX);
      return (ms_ext > max_ext) ? TIME_MAX : TIME_BITS'(ms_ext);
   endfunction

   function automatic logic [1:0] mode_code(turn_mode_type mode);
      logic [1:0] code;
      case (mode)
         MODE_LISTEN: code = CODE_LISTEN;
         MODE_SPEAK:  code = CODE_SPEAK;
         MODE_TRANS:  code = CODE_TRANS;
         default:     code = CODE_LISTEN;
      endcase
      return code;
   endfunction

endpackage

FILE: rtl/rts_step.sv
// per-tick update: phase, sine lookup, gamma smoothing, timers and turn decision
module rts_step (
   input  rts_pkg::cfg_type    cfg,
   input  rts_pkg::state_type  cur,
   input  rts_pkg::item_type   item,
   output rts_pkg::state_type  nxt,
   output rts_pkg::result_type res
);

   logic [rts_pkg::TIME_BITS:0]         dwell_sum;
   logic [rts_pkg::TIME_BITS-1:0]       dwell_adv;
   logic [rts_pkg::TIME_BITS-1:0]       elapsed_ext;
   logic [rts_pkg::TIME_BITS-1:0]       cool_adv;
   logic [rts_pkg::TIME_BITS-1:0]       min_dwell;
   logic [rts_pkg::TIME_BITS-1:0]       cool_load;
   logic [25:0]                         step_prod;
   logic [rts_pkg::PHASE_BITS-1:0]      phase_new;
   logic [rts_pkg::PHASE_BITS+rts_pkg::SINE_TABLE_BITS-1:0] phase_wide;
   logic [rts_pkg::SINE_TABLE_BITS-1:0] sine_idx;
   logic signed [15:0]                  theta;
   logic [19:0]                         gamma_num;
   logic [40:0]                         gamma_prod;
   logic [15:0]                         gamma_new;
   logic                                gate_open;

   assign elapsed_ext = rts_pkg::TIME_BITS'(item.elapsed_ms);
   assign dwell_sum   = {1'b0, cur.dwell} + {1'b0, elapsed_ext};
   assign dwell_adv   = dwell_sum[rts_pkg::TIME_BITS] ? rts_pkg::TIME_MAX
                                                      : dwell_sum[rts_pkg::TIME_BITS-1:0];
   assign cool_adv    = (cur.cooldown > elapsed_ext) ? cur.cooldown - elapsed_ext : '0;
   assign min_dwell   = rts_pkg::cap_time(cfg.min_dwell_ms);
   assign cool_load   = rts_pkg::cap_time(cfg.cooldown_ms);

   assign step_prod = 26'(item.elapsed_ms) * 26'(cfg.phase_step);
   assign phase_new = cur.phase + rts_pkg::PHASE_BITS'(step_prod);

   // top table bits of the phase, or the phase padded with zeros when it is narrower
   assign phase_wide = {phase_new, {rts_pkg::SINE_TABLE_BITS{1'b0}}};
   assign sine_idx   = phase_wide[rts_pkg::PHASE_BITS+rts_pkg::SINE_TABLE_BITS-1 -:
                                  rts_pkg::SINE_TABLE_BITS];
   assign theta      = rts_pkg::SINE_TABLE[sine_idx];

   // g = (9g + sample + 5) / 10
   assign gamma_num  = 20'({4'b0, cur.gamma} * 20'd9) + 20'(item.gamma_sample) + 20'd5;
   assign gamma_prod = 41'(gamma_num) * 41'(rts_pkg::DIV10_MULT);
   assign gamma_new  = gamma_prod[rts_pkg::DIV10_SHIFT +: 16];

   assign gate_open = (cool_adv == '0) && (dwell_adv >= min_dwell);

   always_comb begin
      nxt                  = cur;
      nxt.phase            = phase_new;
      nxt.gamma            = gamma_new;
      nxt.dwell            = dwell_adv;
      nxt.cooldown         = cool_adv;
      if (gate_open) begin
         case (cur.mode)
            rts_pkg::MODE_LISTEN: begin
               if (theta > cfg.speak_theta_thr && item.energy_level > cfg.energy_thr &&
                   gamma_new > cfg.speak_gamma_thr) begin
                  nxt.mode             = rts_pkg::MODE_TRANS;
                  nxt.heading_to_speak = 1'b1;
                  nxt.dwell            = '0;
               end
            end
            rts_pkg::MODE_SPEAK: begin
               if (theta < cfg.listen_theta_thr || gamma_new < rts_pkg::GAMMA_FLOOR ||
                   item.energy_level < cfg.depletion_thr) begin
                  nxt.mode             = rts_pkg::MODE_TRANS;
                  nxt.heading_to_speak = 1'b0;
                  nxt.dwell            = '0;
               end
            end
            rts_pkg::MODE_TRANS: begin
               // completes near a zero crossing
               if (theta < rts_pkg::ZERO_BAND_POS && theta > rts_pkg::ZERO_BAND_NEG) begin
                  nxt.mode     = cur.heading_to_speak ? rts_pkg::MODE_SPEAK
                                                      : rts_pkg::MODE_LISTEN;
                  nxt.cooldown = cool_load;
                  nxt.dwell    = '0;
               end
            end
            default: begin
               // unused mode: timers and phase still advance, the turn stays
               nxt.mode = cur.mode;
            end
         endcase
      end
   end

   assign res.turn_state    = rts_pkg::mode_code(nxt.mode);
   assign res.theta_value   = theta;
   assign res.state_changed = (nxt.mode != cur.mode);

endmodule

FILE: rtl/rhythmic_turn_state_machine.sv
// top level: tick input register, turn state, result register and register port
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | elapsed_ms, energy_level, gamma_sample
//   rsp     | out       | rsp_valid / rsp_stall  | turn_state, theta_value, state_changed
//   csr     | in        | csr_write_en           | csr_index, csr_wdata
//
// one item per cycle sustained while the result is not stalled; an item is held in the input register,
// and its result is written to the result register when that register is free to take it.
// the turn state updates as the item moves on, so consecutive items never wait on each other.
// reset (synchronous) restores listening, zero phase, gamma and timers, and the default
// register values. a stalled result holds the result register; the input register still
// takes an item, and further items stall only once both registers are full.
module rhythmic_turn_state_machine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [9:0]                      req_elapsed_ms,
   input  logic [15:0]                     req_energy_level,
   input  logic [15:0]                     req_gamma_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_turn_state,
   output logic signed [15:0]              rsp_theta_value,
   output logic                            rsp_state_changed,
   input  logic                            csr_write_en,
   input  logic [rts_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rts_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   rts_pkg::cfg_type    cfg_ff, cfg_in;
   rts_pkg::state_type  state_ff, state_in, state_next;
   rts_pkg::item_type   item_ff;
   rts_pkg::result_type res_ff, res_next;
   logic                item_valid_ff, item_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                advance;
   logic                take_req;

   // the item in the input register moves on when the result register is free
   assign advance   = item_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;

   rts_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (state_next),
      .res  (res_next)
   );

   always_comb begin
      item_valid_in = take_req || (item_valid_ff && !advance);
      rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);
      state_in      = advance ? state_next : state_ff;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (rts_pkg::csr_index_type'(csr_index))
            rts_pkg::CSR_PHASE_STEP:       cfg_in.phase_step       = csr_wdata;
            rts_pkg::CSR_SPEAK_THETA_THR:  cfg_in.speak_theta_thr  = csr_wdata;
            rts_pkg::CSR_LISTEN_THETA_THR: cfg_in.listen_theta_thr = csr_wdata;
            rts_pkg::CSR_ENERGY_THR:       cfg_in.energy_thr       = csr_wdata;
            rts_pkg::CSR_DEPLETION_THR:    cfg_in.depletion_thr    = csr_wdata;
            rts_pkg::CSR_SPEAK_GAMMA_THR:  cfg_in.speak_gamma_thr  = csr_wdata;
            rts_pkg::CSR_MIN_DWELL_MS:     cfg_in.min_dwell_ms     = csr_wdata;
            rts_pkg::CSR_COOLDOWN_MS:      cfg_in.cooldown_ms      = csr_wdata;
            default:                       cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff             <= 1'b0;
         rsp_valid_ff              <= 1'b0;
         state_ff.mode             <= rts_pkg::MODE_LISTEN;
         state_ff.heading_to_speak <= 1'b0;
         state_ff.phase            <= '0;
         state_ff.gamma            <= '0;
         state_ff.dwell            <= '0;
         state_ff.cooldown         <= '0;
         cfg_ff.phase_step         <= rts_pkg::RST_PHASE_STEP;
         cfg_ff.speak_theta_thr    <= rts_pkg::RST_SPEAK_THETA_THR;
         cfg_ff.listen_theta_thr   <= rts_pkg::RST_LISTEN_THETA_THR;
         cfg_ff.energy_thr         <= rts_pkg::RST_ENERGY_THR;
         cfg_ff.depletion_thr      <= rts_pkg::RST_DEPLETION_THR;
         cfg_ff.speak_gamma_thr    <= rts_pkg::RST_SPEAK_GAMMA_THR;
         cfg_ff.min_dwell_ms       <= rts_pkg::RST_MIN_DWELL_MS;
         cfg_ff.cooldown_ms        <= rts_pkg::RST_COOLDOWN_MS;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
         cfg_ff        <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         item_ff.elapsed_ms   <= req_elapsed_ms;
         item_ff.energy_level <= req_energy_level;
         item_ff.gamma_sample <= req_gamma_sample;
      end
      if (advance) begin
         res_ff <= res_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_turn_state    = res_ff.turn_state;
   assign rsp_theta_value   = res_ff.theta_value;
   assign rsp_state_changed = res_ff.state_changed;

endmodule

FILE: rtl/rts_checker.sv
// port-level checker for the rhythmic turn state machine, bound to the top level
module rts_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_turn_state,
   input logic signed [15:0] rsp_theta_value,
   input logic               rsp_state_changed
);

   logic [1:0] last_state_ff, last_state_in;
   logic       rsp_take;

   assign rsp_take      = rsp_valid && !rsp_stall;
   assign last_state_in = rsp_take ? rsp_turn_state : last_state_ff;

   // turn state of the last delivered item
   always_ff @(posedge clock) begin
      if (reset) begin
         last_state_ff <= rts_pkg::CODE_LISTEN;
      end else begin
         last_state_ff <= last_state_in;
      end
   end

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_turn_state) &&
                                 $stable(rsp_theta_value) && $stable(rsp_state_changed))
      else $error("stalled result changed");

   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> rsp_state_changed == (rsp_turn_state != last_state_ff))
      else $error("state_changed disagrees with the item stream");

   a_through_trans: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_state_changed |->
         rsp_turn_state == rts_pkg::CODE_TRANS || last_state_ff == rts_pkg::CODE_TRANS)
      else $error("turn changed without passing through transitioning");

   a_valid_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_turn_state == rts_pkg::CODE_LISTEN ||
                    rsp_turn_state == rts_pkg::CODE_SPEAK ||
                    rsp_turn_state == rts_pkg::CODE_TRANS)
      else $error("unused turn state code");

endmodule

bind rhythmic_turn_state_machine rts_checker u_rts_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_turn_state    (rsp_turn_state),
   .rsp_theta_value   (rsp_theta_value),
   .rsp_state_changed (rsp_state_changed)
);

FILE: tb/sv/tb_top.sv
// self-checking testbench for the rhythmic turn state machine: random ticks against a predictor
`timescale 1ns / 100ps

module tb_top;
   import rts_pkg::*;

   localparam logic [15:0]        GAMMA_LOW    = 16'd38;
   localparam logic signed [15:0] NEAR_ZERO    = 16'sd4915;
   localparam int                 RANDOM_ITEMS = 850;

   typedef enum int {MOOD_TAKE, MOOD_YIELD, MOOD_NOISE} mood_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [9:0]               req_elapsed_ms;
   logic [15:0]              req_energy_level;
   logic [15:0]              req_gamma_sample;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [1:0]               rsp_turn_state;
   logic signed [15:0]       rsp_theta_value;
   logic                     rsp_state_changed;
   logic                     csr_write_en;
   logic [CSR_INDEX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;

   // predicted block state and settings
   logic [15:0] turn_cfg [8];
   logic [1:0]  mode_now;
   logic        heading_speak;
   logic [15:0] phase_now;
   logic [15:0] gamma_avg;
   logic [15:0] dwell_ms;
   logic [15:0] cool_ms;

   item_type    item_queue [$];
   result_type  expected_turns [$];
   int          fault_count = 0;
   int          send_gap = 0;
   int          hold_left = 0;
   bit          req_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;
   bit          req_took = 1'b0;

   rhythmic_turn_state_machine dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_elapsed_ms    (req_elapsed_ms),
      .req_energy_level  (req_energy_level),
      .req_gamma_sample  (req_gamma_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_turn_state    (rsp_turn_state),
      .rsp_theta_value   (rsp_theta_value),
      .rsp_state_changed (rsp_state_changed),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // quarter-wave sine, odd polynomial in q30, rounded to q1.15
   function automatic logic signed [15:0] theta_lookup(logic [7:0] slot);
      logic [1:0] quadrant;
      int         span;
      longint     arg;
      longint     arg_sq;
      longint     poly;
      longint     acc;
      quadrant = slot[7:6];
      span     = quadrant[0] ? 64 - int'(slot[5:0]) : int'(slot[5:0]);
      arg      = longint'(span) << 24;
      arg_sq   = (arg * arg) >>> 30;
      poly     = 172272;
      poly     = 5026994 - ((poly * arg_sq) >>> 30);
      poly     = 85569306 - ((poly * arg_sq) >>> 30);
      poly     = 693598669 - ((poly * arg_sq) >>> 30);
      poly     = 1686629713 - ((poly * arg_sq) >>> 30);
      acc      = (arg * poly) >>> 30;
      acc      = (acc + 16384) >>> 15;
      if (acc > 32767) begin
         acc = 32767;
      end
      if (quadrant[1]) begin
         acc = -acc;
      end
      return 16'(acc);
   endfunction

   task automatic step_turn(input item_type tick, output result_type res);
      logic [1:0]         prior_mode;
      logic [16:0]        dwell_sum;
      int unsigned        gamma_sum;
      logic signed [15:0] theta;
      prior_mode = mode_now;
      dwell_sum  = 17'(dwell_ms) + 17'(tick.elapsed_ms);
      dwell_ms   = dwell_sum[16] ? 16'hFFFF : dwell_sum[15:0];
      if (cool_ms != 16'd0) begin
         cool_ms = (cool_ms > 16'(tick.elapsed_ms)) ? cool_ms - 16'(tick.elapsed_ms) : 16'd0;
      end
      phase_now = 16'(32'(phase_now) + 32'(tick.elapsed_ms) * 32'(turn_cfg[CSR_PHASE_STEP]));
      gamma_sum = 9 * int'(gamma_avg) + int'(tick.gamma_sample) + 5;
      gamma_avg = 16'(gamma_sum / 10);
      theta     = theta_lookup(phase_now[15:8]);

      if (cool_ms == 16'd0 && dwell_ms >= turn_cfg[CSR_MIN_DWELL_MS]) begin
         case (mode_now)
            CODE_LISTEN: begin
               if (theta > $signed(turn_cfg[CSR_SPEAK_THETA_THR]) &&
                   tick.energy_level > turn_cfg[CSR_ENERGY_THR] &&
                   gamma_avg > turn_cfg[CSR_SPEAK_GAMMA_THR]) begin
                  mode_now      = CODE_TRANS;
                  heading_speak = 1'b1;
                  dwell_ms      = 16'd0;
               end
            end
            CODE_SPEAK: begin
               if (theta < $signed(turn_cfg[CSR_LISTEN_THETA_THR]) ||
                   gamma_avg < GAMMA_LOW ||
                   tick.energy_level < turn_cfg[CSR_DEPLETION_THR]) begin
                  mode_now      = CODE_TRANS;
                  heading_speak = 1'b0;
                  dwell_ms      = 16'd0;
               end
            end
            CODE_TRANS: begin
               // completes only near a zero crossing of theta
               if (theta < NEAR_ZERO && theta > -NEAR_ZERO) begin
                  mode_now = heading_speak ? CODE_SPEAK : CODE_LISTEN;
                  cool_ms  = turn_cfg[CSR_COOLDOWN_MS];
                  dwell_ms = 16'd0;
               end
            end
            default: begin
            end
         endcase
      end

      res.turn_state    = mode_now;
      res.theta_value   = theta;
      res.state_changed = (mode_now != prior_mode);
   endtask

   // mostly back to back, some short gaps, a few long ones
   function automatic int draw_gap(bit quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 30);
   endfunction

   function automatic item_type make_tick(mood_type mood, bit long_ticks);
      item_type tick;
      int       roll;
      roll = $urandom_range(0, 99);
      if (long_ticks) begin
         tick.elapsed_ms = (roll < 80) ? 10'd1023 : 10'($urandom_range(900, 1023));
      end else if (roll < 60) begin
         tick.elapsed_ms = 10'($urandom_range(1, 64));
      end else if (roll < 85) begin
         tick.elapsed_ms = 10'($urandom_range(0, 1023));
      end else begin
         tick.elapsed_ms = (roll < 93) ? 10'd0 : 10'd1023;
      end
      roll = $urandom_range(0, 99);
      case (mood)
         MOOD_TAKE: begin
            tick.energy_level = 16'($urandom_range(16'hFFFF, turn_cfg[CSR_ENERGY_THR]));
            tick.gamma_sample = 16'($urandom_range(16'hFFFF, turn_cfg[CSR_SPEAK_GAMMA_THR]));
         end
         MOOD_YIELD: begin
            tick.energy_level = (roll < 50) ?
               16'($urandom_range(turn_cfg[CSR_DEPLETION_THR], 0)) : 16'($urandom);
            tick.gamma_sample = 16'($urandom_range(0, 40));
         end
         default: begin
            tick.energy_level = (roll < 10) ? {16{1'($urandom_range(0, 1))}} : 16'($urandom);
            tick.gamma_sample = (roll > 89) ? {16{1'($urandom_range(0, 1))}} : 16'($urandom);
         end
      endcase
      return tick;
   endfunction

   task automatic queue_tick(input logic [9:0] elapsed, input logic [15:0] energy,
                             input logic [15:0] gamma);
      item_type tick;
      tick.elapsed_ms   = elapsed;
      tick.energy_level = energy;
      tick.gamma_sample = gamma;
      item_queue.push_back(tick);
   endtask

   task automatic write_reg(input csr_index_type sel, input logic [15:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= sel;
      csr_wdata    <= value;
      turn_cfg[sel] = value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic drain();
      while (item_queue.size() != 0 || expected_turns.size() != 0) begin
         @(negedge clock);
      end
      repeat (6) @(negedge clock);
   endtask

   // sender: next item goes out once the current one is taken and its gap has passed
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (item_queue.size() != 0) begin
            req_valid        <= 1'b1;
            req_elapsed_ms   <= item_queue[0].elapsed_ms;
            req_energy_level <= item_queue[0].energy_level;
            req_gamma_sample <= item_queue[0].gamma_sample;
            send_gap         <= draw_gap(req_quiet);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         hold_left <= draw_gap(rsp_quiet);
      end
   end

   always @(posedge clock) begin
      item_type   tick;
      result_type want;
      result_type got;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            tick.elapsed_ms   = req_elapsed_ms;
            tick.energy_level = req_energy_level;
            tick.gamma_sample = req_gamma_sample;
            step_turn(tick, want);
            expected_turns.push_back(want);
            if (item_queue.size() != 0) begin
               void'(item_queue.pop_front());
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got.turn_state    = rsp_turn_state;
            got.theta_value   = rsp_theta_value;
            got.state_changed = rsp_state_changed;
            if (expected_turns.size() == 0) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("turn result with no item pending: state %0d theta %0d changed %0b",
                           got.turn_state, got.theta_value, got.state_changed);
               end
            end else begin
               want = expected_turns.pop_front();
               if (got.turn_state !== want.turn_state || got.theta_value !== want.theta_value ||
                   got.state_changed !== want.state_changed) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("turn result mismatch: state %0d (want %0d) theta %0d (want %0d) %s",
                              got.turn_state, want.turn_state, got.theta_value,
                              want.theta_value,
                              $sformatf("changed %0b (want %0b)", got.state_changed,
                                        want.state_changed));
                  end
               end
            end
         end
      end
   end

   initial begin
      logic [15:0]   plan [8];
      csr_index_type sel;
      mood_type      mood;
      int            mood_left;
      int            phase_no;
      int            random_sent;
      int            batch;
      int            roll;
      bit            long_ticks;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_elapsed_ms   = '0;
      req_energy_level = '0;
      req_gamma_sample = '0;
      rsp_stall        = 1'b0;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;

      turn_cfg[CSR_PHASE_STEP]       = 16'd393;
      turn_cfg[CSR_SPEAK_THETA_THR]  = 16'd21299;
      turn_cfg[CSR_LISTEN_THETA_THR] = 16'(-9830);
      turn_cfg[CSR_ENERGY_THR]       = 16'd128;
      turn_cfg[CSR_DEPLETION_THR]    = 16'd51;
      turn_cfg[CSR_SPEAK_GAMMA_THR]  = 16'd102;
      turn_cfg[CSR_MIN_DWELL_MS]     = 16'd800;
      turn_cfg[CSR_COOLDOWN_MS]      = 16'd500;
      mode_now      = CODE_LISTEN;
      heading_speak = 1'b0;
      phase_now     = '0;
      gamma_avg     = '0;
      dwell_ms      = '0;
      cool_ms       = '0;
      mood          = MOOD_NOISE;
      mood_left     = 0;
      random_sent   = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed ticks on the reset settings: field corners, a turn taken and yielded
      @(posedge clock);
      queue_tick(10'd0, 16'h0000, 16'h0000);
      queue_tick(10'd1023, 16'hFFFF, 16'hFFFF);
      queue_tick(10'd1, 16'h0000, 16'hFFFF);
      queue_tick(10'd1023, 16'hFFFF, 16'h0000);
      repeat (8) queue_tick(10'd1023, 16'hFFFF, 16'hFFFF);
      repeat (6) queue_tick(10'd1023, 16'h0000, 16'h0000);
      queue_tick(10'd512, 16'h5555, 16'hAAAA);
      queue_tick(10'd511, 16'hAAAA, 16'h5555);
      drain();

      phase_no = 0;
      while (random_sent < RANDOM_ITEMS) begin
         phase_no++;
         long_ticks = 1'b0;
         batch      = $urandom_range(60, 120);
         case (phase_no)
            1: begin
               // permissive low corner: frozen phase, no dwell, no cooldown
               plan[CSR_PHASE_STEP]       = 16'h0000;
               plan[CSR_SPEAK_THETA_THR]  = 16'h8000;
               plan[CSR_LISTEN_THETA_THR] = 16'h7FFF;
               plan[CSR_ENERGY_THR]       = 16'h0000;
               plan[CSR_DEPLETION_THR]    = 16'hFFFF;
               plan[CSR_SPEAK_GAMMA_THR]  = 16'h0000;
               plan[CSR_MIN_DWELL_MS]     = 16'h0000;
               plan[CSR_COOLDOWN_MS]      = 16'h0000;
               batch = 40;
            end
            2: begin
               // strict high corner: nothing may move, timers saturate
               plan[CSR_PHASE_STEP]       = 16'hFFFF;
               plan[CSR_SPEAK_THETA_THR]  = 16'h7FFF;
               plan[CSR_LISTEN_THETA_THR] = 16'h8000;
               plan[CSR_ENERGY_THR]       = 16'hFFFF;
               plan[CSR_DEPLETION_THR]    = 16'h0000;
               plan[CSR_SPEAK_GAMMA_THR]  = 16'hFFFF;
               plan[CSR_MIN_DWELL_MS]     = 16'hFFFF;
               plan[CSR_COOLDOWN_MS]      = 16'hFFFF;
               long_ticks = 1'b1;
               batch = 40;
            end
            3: begin
               // easy triggers but full dwell and cooldown: turns only after saturation
               plan[CSR_PHASE_STEP]       = 16'($urandom);
               plan[CSR_SPEAK_THETA_THR]  = 16'h8000;
               plan[CSR_LISTEN_THETA_THR] = 16'h7FFF;
               plan[CSR_ENERGY_THR]       = 16'h0000;
               plan[CSR_DEPLETION_THR]    = 16'h0000;
               plan[CSR_SPEAK_GAMMA_THR]  = 16'h0000;
               plan[CSR_MIN_DWELL_MS]     = 16'hFFFF;
               plan[CSR_COOLDOWN_MS]      = 16'hFFFF;
               long_ticks = 1'b1;
               batch = 200;
            end
            default: begin
               roll = $urandom_range(0, 99);
               if (roll < 70) begin
                  plan[CSR_PHASE_STEP] = 16'($urandom_range(50, 3000));
               end else if (roll < 90) begin
                  plan[CSR_PHASE_STEP] = 16'($urandom);
               end else begin
                  plan[CSR_PHASE_STEP] = roll[0] ? 16'hFFFF : 16'h0001;
               end
               plan[CSR_SPEAK_THETA_THR]  = ($urandom_range(0, 9) == 0) ?
                  16'($urandom) : 16'($urandom_range(5000, 30000));
               plan[CSR_LISTEN_THETA_THR] = ($urandom_range(0, 9) == 0) ?
                  16'($urandom) : 16'(-int'($urandom_range(0, 20000)));
               plan[CSR_ENERGY_THR]       = 16'($urandom_range(0, 2000));
               plan[CSR_DEPLETION_THR]    = 16'($urandom_range(0, 300));
               plan[CSR_SPEAK_GAMMA_THR]  = 16'($urandom_range(0, 2000));
               plan[CSR_MIN_DWELL_MS]     = ($urandom_range(0, 9) == 0) ?
                  16'($urandom) : 16'($urandom_range(0, 300));
               plan[CSR_COOLDOWN_MS]      = ($urandom_range(0, 9) == 0) ?
                  16'($urandom) : 16'($urandom_range(0, 300));
            end
         endcase
         if (batch > RANDOM_ITEMS - random_sent) begin
            batch = RANDOM_ITEMS - random_sent;
         end

         sel = sel.first();
         repeat (sel.num()) begin
            write_reg(sel, plan[sel]);
            sel = sel.next();
         end

         @(posedge clock);
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         repeat (batch) begin
            if (mood_left == 0) begin
               roll      = $urandom_range(0, 99);
               mood      = (roll < 40) ? MOOD_TAKE : (roll < 70) ? MOOD_YIELD : MOOD_NOISE;
               mood_left = $urandom_range(5, 40);
            end
            mood_left--;
            item_queue.push_back(make_tick(mood, long_ticks));
            random_sent++;
         end
         // sender holds off here until every result of the batch is back
         drain();
      end

      fault_count += expected_turns.size();
      if (fault_count == 0) begin
         $display("rhythmic_turn_state_machine verification clean");
      end else begin
         $display("rhythmic_turn_state_machine verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("rhythmic_turn_state_machine verification failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/rts_pkg.sv
rtl/rts_step.sv
rtl/rhythmic_turn_state_machine.sv
rtl/rts_checker.sv
tb/sv/tb_top.sv
